// ----- rtl/dffg_pkg.sv -----
// dffg_pkg: shared types, widths and state codes for the disk form factor gather
// no dependencies
package dffg_pkg;

  localparam int COMP_DEF = 21;
  localparam int VEC_W    = 63;
  localparam int RAD_W    = 20;
  localparam int OUT_W    = 32;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 96;
  localparam int NUM_W    = 66;
  localparam int DEN_W    = 48;
  localparam int CNT_W    = $clog2(NUM_W + 1);

  typedef struct packed {
    logic             kind;
    logic [VEC_W-1:0] rcv_pos;
    logic [VEC_W-1:0] rcv_nrm;
    logic [VEC_W-1:0] emit_pos;
    logic [VEC_W-1:0] emit_nrm;
    logic [VEC_W-1:0] emit_rad;
    logic [RAD_W-1:0] emit_radius;
    logic             last;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sum_red;
    logic signed [OUT_W-1:0] sum_green;
    logic signed [OUT_W-1:0] sum_blue;
    logic signed [OUT_W-1:0] occlusion;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOT,
    ST_DOTEND,
    ST_STRAD,
    ST_SQ,
    ST_FRONT,
    ST_AB,
    ST_DIV1,
    ST_DIV2,
    ST_FF,
    ST_COL,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    DS_CULL,
    DS_T,
    DS_NN,
    DS_PN,
    DS_DD,
    DS_PR
  } dsel_t;

endpackage

// ----- rtl/dffg_mul.sv -----
// dffg_mul: shared signed multiplier with registered product
// depends on dffg_pkg
module dffg_mul import dffg_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ----- rtl/dffg_div.sv -----
// dffg_div: restoring divider, one quotient bit per cycle
// depends on dffg_pkg
module dffg_div import dffg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  logic [NUM_W-1:0] qn;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dv;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, qn[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dv};
  assign quo    = qn;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        qn   <= num;
        dv   <= den;
        rem  <= '0;
        cnt  <= CNT_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? DEN_W'(rem_sh - {1'b0, dv}) : DEN_W'(rem_sh);
        qn  <= {qn[NUM_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/disk_form_factor_gather.sv -----
// disk_form_factor_gather: top level, sequencer and datapath around the shared units
// depends on dffg_pkg, dffg_mul, dffg_div
//
// Gathers disk form factors for one receiver point: each transfer on the item channel
// brings one emitter, and the transfer marked last produces one result with the saturated
// colour and occlusion sums, after which the sums are cleared. Items are taken one at a
// time; an item holds the input until it is finished, whether it is rejected by its
// first dot product or fully processed. The processing is sequenced through one shared
// 33x33 multiplier issuing every product in turn and the shared restoring divider, which
// performs the two divisions one after the other. A result waits in its output register
// while further items are accepted; the next last item holds in its final state until
// the waiting result is taken.
module disk_form_factor_gather import dffg_pkg::*; #(
  parameter int COMP_WIDTH = COMP_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    item_valid,
  output logic    item_stall,
  output result_t result,
  output logic    result_valid,
  input  logic    result_stall
);

  localparam int CW = COMP_WIDTH;

  state_t state, state_next;
  dsel_t  dsel;
  item_t  it;
  logic [2:0] k;
  logic [1:0] ci;

  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] preg;
  logic signed [MUL_W-1:0]  ma, mb;
  logic signed [23:0]       dv [3];
  logic signed [47:0]       t;
  logic [22:0]              nn;
  logic [40:0]              ss;
  logic [34:0]              ra2;
  logic [45:0]              d2;
  logic [24:0]              av, bmag;
  logic                     bneg;
  logic [62:0]              cmag, rr;
  logic [30:0]              ffm;
  logic signed [OUT_W-1:0]  acc_c [3];
  logic signed [OUT_W-1:0]  acc_o;

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic [62:0]      satq;

  logic signed [21:0] rp [3], ep [3], d [3];
  logic signed [20:0] rn [3], en [3];
  logic [20:0]        ch [3];

  logic signed [ACC_W-1:0] psum, smag, sr, qsq, na, bm, ffp, ffr, cv;
  logic signed [47:0]      rr48, hv, sv, tv;
  logic [41:0]             nsum;
  logic [40:0]             ffront;
  logic [21:0]             soff;
  logic signed [23:0]      off;
  logic                    acc_nonneg, acc_pos, t_below, t_strad, ff_short;
  logic signed [37:0]      csv, osv;
  logic [1:0]              cidx;

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [38:0] v);
    if (v > 39'sd2147483647) return 32'sh7fffffff;
    else if (v < -39'sd2147483648) return 32'sh80000000;
    else return v[OUT_W-1:0];
  endfunction

  dffg_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(preg));

  dffg_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rp[i] = 22'($signed(it.rcv_pos[i*CW +: CW]));
      ep[i] = 22'($signed(it.emit_pos[i*CW +: CW]));
      rn[i] = 21'($signed(it.rcv_nrm[i*CW +: CW]));
      en[i] = 21'($signed(it.emit_nrm[i*CW +: CW]));
      ch[i] = 21'(it.emit_rad[i*CW +: CW]);
      d[i]  = ep[i] - rp[i];
    end
  end

  assign item_stall = (state != ST_IDLE);
  assign satq       = (div_quo[NUM_W-1:63] != '0) ? 63'h4000000000000000 : div_quo[62:0];

  assign psum       = acc + ACC_W'(preg);
  assign acc_nonneg = !acc[ACC_W-1];
  assign acc_pos    = !acc[ACC_W-1] && (acc != '0);
  assign rr48       = $signed({9'd0, it.emit_radius, 19'd0});
  assign tv         = acc[47:0];
  assign t_below    = tv < -rr48;
  assign t_strad    = tv < rr48;
  assign hv         = rr48 - t;
  assign sv         = rr48 + t + 48'sd524288;
  assign nsum       = acc[41:0] + 42'd262144;
  assign smag       = psum[ACC_W-1] ? -psum : psum;
  assign sr         = smag + (ACC_W'(1) <<< 38);
  assign soff       = sr[60:39];
  assign off        = psum[ACC_W-1] ? -24'($signed({1'b0, soff})) : 24'($signed({1'b0, soff}));
  assign qsq        = psum + (ACC_W'(1) <<< 28);
  assign ffront     = 41'(preg[40:0] + 41'd512);
  assign na         = -acc + (ACC_W'(1) <<< 18);
  assign bm         = (acc[ACC_W-1] ? -acc : acc) + (ACC_W'(1) <<< 18);
  assign ffp        = acc + (ACC_W'(preg) <<< 48);
  assign ffr        = ffp + (ACC_W'(1) <<< 15);
  assign cv         = ACC_W'(preg) + (ACC_W'(1) <<< 15);
  assign csv        = bneg ? -38'($signed({1'b0, cv[52:16]})) : 38'($signed({1'b0, cv[52:16]}));
  assign osv        = bneg ? -38'($signed({1'b0, ffm})) : 38'($signed({1'b0, ffm}));
  assign cidx       = 2'(k - 3'd1);
  assign ff_short   = (cmag == '0) || (rr == '0) || (cmag[62:47] != '0) || (rr[62:47] != '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (item_valid) state_next = ST_DOT;
      ST_DOT:    if (k == 3'd3) state_next = ST_DOTEND;
      ST_DOTEND: begin
        unique case (dsel)
          DS_CULL: state_next = acc_nonneg ? ST_FIN : ST_DOT;
          DS_T:    state_next = t_below ? ST_FIN : (t_strad ? ST_DOT : ST_FRONT);
          DS_NN:   state_next = ST_STRAD;
          DS_PN:   state_next = acc_nonneg ? ST_FIN : ST_DOT;
          DS_DD:   state_next = acc_pos ? ST_DOT : ST_FIN;
          DS_PR:   state_next = ST_AB;
          default: state_next = ST_FIN;
        endcase
      end
      ST_STRAD:  if (k == 3'd2 && ci == 2'd2) state_next = ST_SQ;
      ST_SQ:     if (k == 3'd4) state_next = ST_DOT;
      ST_FRONT:  if (k == 3'd1) state_next = ST_DOT;
      ST_AB:     if (k == 3'd1) state_next = ST_DIV1;
      ST_DIV1:   if (div_done) state_next = ST_DIV2;
      ST_DIV2:   if (div_done) state_next = ST_FF;
      ST_FF:     if ((k == 3'd0 && ff_short) || k == 3'd4) state_next = ST_COL;
      ST_COL:    if (k == 3'd3) state_next = ST_FIN;
      ST_FIN:    if (!it.last || !result_valid || !result_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // shared unit operands
  always_comb begin
    ma        = '0;
    mb        = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state)
      ST_DOT: begin
        if (k < 3'd3) begin
          case (dsel)
            DS_CULL: begin ma = MUL_W'(d[k[1:0]]);  mb = MUL_W'(en[k[1:0]]); end
            DS_T:    begin ma = MUL_W'(d[k[1:0]]);  mb = MUL_W'(rn[k[1:0]]); end
            DS_NN:   begin ma = MUL_W'(rn[k[1:0]]); mb = MUL_W'(rn[k[1:0]]); end
            DS_PN:   begin ma = MUL_W'(dv[k[1:0]]); mb = MUL_W'(en[k[1:0]]); end
            DS_DD:   begin ma = MUL_W'(dv[k[1:0]]); mb = MUL_W'(dv[k[1:0]]); end
            DS_PR:   begin ma = MUL_W'(dv[k[1:0]]); mb = MUL_W'(rn[k[1:0]]); end
            default: begin ma = '0; mb = '0; end
          endcase
        end
      end
      ST_STRAD: begin
        ma = MUL_W'(rn[ci]);
        mb = (k == 3'd0) ? MUL_W'(hv[40:20]) : MUL_W'(hv[19:0]);
      end
      ST_SQ: begin
        if (k == 3'd0) begin
          ma = MUL_W'(sv[40:20]);
          mb = MUL_W'(sv[40:20]);
        end else begin
          ma = (k == 3'd2) ? MUL_W'(ss[40:20]) : MUL_W'(ss[19:0]);
          mb = MUL_W'(nn);
        end
      end
      ST_FRONT: begin
        ma = MUL_W'(it.emit_radius);
        mb = MUL_W'(it.emit_radius);
      end
      ST_AB: begin
        ma = MUL_W'(av);
        mb = MUL_W'(bmag);
        if (k == 3'd1) begin
          div_start = 1'b1;
          div_num   = {preg[49:0], 16'd0};
          div_den   = DEN_W'(d2);
        end
      end
      ST_DIV1: begin
        div_start = div_done;
        div_num   = NUM_W'({ra2, 26'd0});
        div_den   = DEN_W'(d2) + DEN_W'(1);
      end
      ST_FF: begin
        ma = (k < 3'd2) ? MUL_W'(cmag[23:0]) : MUL_W'(cmag[46:24]);
        mb = (k == 3'd0 || k == 3'd2) ? MUL_W'(rr[23:0]) : MUL_W'(rr[46:24]);
      end
      ST_COL: begin
        if (k < 3'd3) begin
          ma = MUL_W'(ffm);
          mb = MUL_W'(ch[k[1:0]]);
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      k            <= '0;
      ci           <= '0;
      dsel         <= DS_T;
      result_valid <= 1'b0;
      acc_o        <= '0;
      for (int i = 0; i < 3; i++) acc_c[i] <= '0;
    end else begin
      state <= state_next;
      if (state_next != state || (state == ST_STRAD && k == 3'd2)) k <= '0;
      else k <= k + 3'd1;
      if (state == ST_FIN && it.last && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            it   <= item;
            dsel <= item.kind ? DS_T : DS_CULL;
          end
        end
        ST_DOT: begin
          if (k == 3'd1) acc <= ACC_W'(preg);
          else if (k != 3'd0) acc <= psum;
        end
        ST_DOTEND: begin
          unique case (dsel)
            DS_CULL: dsel <= DS_T;
            DS_T: begin
              t <= tv;
              if (t_strad) dsel <= DS_NN;
              for (int i = 0; i < 3; i++) dv[i] <= 24'(d[i]);
            end
            DS_NN: begin
              nn <= nsum[41:19];
              ci <= '0;
            end
            DS_PN: begin
              av   <= na[43:19];
              dsel <= DS_DD;
            end
            DS_DD: begin
              d2   <= acc[45:0];
              dsel <= DS_PR;
            end
            DS_PR: begin
              bmag <= bm[43:19];
              bneg <= acc[ACC_W-1];
            end
            default: dsel <= DS_T;
          endcase
        end
        ST_STRAD: begin
          if (k == 3'd1) acc <= ACC_W'(preg) <<< 20;
          if (k == 3'd2) begin
            dv[ci] <= 24'(d[ci]) + off;
            ci     <= ci + 2'd1;
          end
        end
        ST_SQ: begin
          if (k == 3'd1) ss <= preg[40:0];
          if (k == 3'd3) acc <= ACC_W'(preg) <<< 20;
          if (k == 3'd4) begin
            ra2  <= qsq[63:29];
            dsel <= DS_PN;
          end
        end
        ST_FRONT: begin
          if (k == 3'd1) begin
            ra2  <= 35'(ffront[40:10]);
            dsel <= DS_PN;
          end
        end
        ST_DIV1: if (div_done) cmag <= satq;
        ST_DIV2: if (div_done) rr <= satq;
        ST_FF: begin
          unique case (k)
            3'd0: begin
              if ((cmag == '0) || (rr == '0)) ffm <= '0;
              else if (ff_short) ffm <= 31'h7fffffff;
            end
            3'd1: acc <= ACC_W'(preg);
            3'd2, 3'd3: acc <= acc + (ACC_W'(preg) <<< 24);
            3'd4: ffm <= (ffr[95:47] != '0) ? 31'h7fffffff : ffr[46:16];
            default: acc <= acc;
          endcase
        end
        ST_COL: begin
          if (k != 3'd0) acc_c[cidx] <= sat32(39'(acc_c[cidx]) + 39'(csv));
          if (k == 3'd3) acc_o <= sat32(39'(acc_o) + 39'(osv));
        end
        ST_FIN: begin
          if (it.last && (!result_valid || !result_stall)) begin
            result.sum_red   <= acc_c[0];
            result.sum_green <= acc_c[1];
            result.sum_blue  <= acc_c[2];
            result.occlusion <= acc_o;
            acc_o            <= '0;
            for (int i = 0; i < 3; i++) acc_c[i] <= '0;
          end
        end
        default: acc <= acc;
      endcase
    end
  end

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV1 || state == ST_DIV2))
    else $error("divider finished outside a division step");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == ST_FIN && $past(it.last)))
    else $error("result raised without a last item");

  a_sums_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && it.last && (!result_valid || !result_stall))
      |=> (acc_o == '0 && acc_c[0] == '0 && acc_c[1] == '0 && acc_c[2] == '0))
    else $error("sums not cleared after result");

endmodule
